// File: hdl/atrlp_pkg.sv
// package for the at response line parser
// result type, character and state codes, prefix lookup functions
// no dependencies

package atrlp_pkg;

  // characters with special meaning
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_VT   = 8'h0B;
  localparam logic [7:0] CHAR_FF   = 8'h0C;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  // prefix lengths
  localparam int unsigned STAT_PREFIX_LEN  = 9;
  localparam int unsigned AUDIO_PREFIX_LEN = 10;

  // prefix match bits
  localparam int unsigned PM_STATUS_BIT = 0;
  localparam int unsigned PM_AUDIO_BIT  = 1;

  // number reading phase codes
  localparam logic [1:0] PH_BLANKS = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // line kind codes
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_AUDIO  = 2'd2;

  // one result transaction
  typedef struct packed {
    logic        receiver_halted;
    logic        audio_update;
    logic [31:0] audio_value;
    logic [31:0] status_value;
    logic [1:0]  line_kind;
  } atrlp_result_t;

  // expected character of "+HFPSTAT=" at a position
  function automatic logic [7:0] stat_char(logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h2B; // +
      4'd1:    ch = 8'h48; // H
      4'd2:    ch = 8'h46; // F
      4'd3:    ch = 8'h50; // P
      4'd4:    ch = 8'h53; // S
      4'd5:    ch = 8'h54; // T
      4'd6:    ch = 8'h41; // A
      4'd7:    ch = 8'h54; // T
      4'd8:    ch = 8'h3D; // =
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // expected character of "+HFPAUDIO=" at a position
  function automatic logic [7:0] audio_char(logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h2B; // +
      4'd1:    ch = 8'h48; // H
      4'd2:    ch = 8'h46; // F
      4'd3:    ch = 8'h50; // P
      4'd4:    ch = 8'h41; // A
      4'd5:    ch = 8'h55; // U
      4'd6:    ch = 8'h44; // D
      4'd7:    ch = 8'h49; // I
      4'd8:    ch = 8'h4F; // O
      4'd9:    ch = 8'h3D; // =
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/atrlp_line.sv
// line state and parsing step of the at response line parser
// updates prefix match, number reading and stored values for one byte
// depends on atrlp_pkg

module atrlp_line #(
  parameter int unsigned LINE_MAX    = 256,
  parameter int unsigned STATUS_INIT = 0,
  parameter int unsigned AUDIO_INIT  = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,      // process rx_byte_i this cycle
  input  logic [7:0]              rx_byte_i,
  output logic                    res_valid_o,
  output atrlp_pkg::atrlp_result_t res_o
);

  localparam int unsigned LW = $clog2(LINE_MAX + 1);

  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] eff_len_q, eff_len_d;
  logic [1:0]    pm_q, pm_d;
  logic          zero_q, zero_d;
  logic [1:0]    phase_q, phase_d;
  logic          neg_q, neg_d;
  logic [31:0]   acc_q, acc_d;
  logic [31:0]   status_q, status_d;
  logic [31:0]   audio_q, audio_d;
  logic          halted_q, halted_d;

  logic [LW-1:0] eff;
  logic [31:0]   value;
  logic          is_digit;
  logic          is_blank;
  logic [7:0]    digit_val;
  logic [1:0]    pm_new;
  logic          feed;

  // character classes
  assign is_digit  = (rx_byte_i >= atrlp_pkg::CHAR_0) && (rx_byte_i <= atrlp_pkg::CHAR_9);
  assign is_blank  = (rx_byte_i == atrlp_pkg::CHAR_SP) || (rx_byte_i == atrlp_pkg::CHAR_TAB) ||
                     (rx_byte_i == atrlp_pkg::CHAR_VT) || (rx_byte_i == atrlp_pkg::CHAR_FF);
  assign digit_val = rx_byte_i - atrlp_pkg::CHAR_0;

  // length used for the prefix check at line end
  always_comb begin
    if (zero_q) begin
      eff = eff_len_q;
    end else if (len_q >= LW'(LINE_MAX)) begin
      eff = '0;
    end else begin
      eff = len_q;
    end
  end

  assign value = neg_q ? (32'd0 - acc_q) : acc_q;

  // prefix match after this byte
  always_comb begin
    pm_new = pm_q;
    if (len_q < LW'(atrlp_pkg::STAT_PREFIX_LEN) &&
        rx_byte_i != atrlp_pkg::stat_char(len_q[3:0])) begin
      pm_new[atrlp_pkg::PM_STATUS_BIT] = 1'b0;
    end
    if (len_q < LW'(atrlp_pkg::AUDIO_PREFIX_LEN) &&
        rx_byte_i != atrlp_pkg::audio_char(len_q[3:0])) begin
      pm_new[atrlp_pkg::PM_AUDIO_BIT] = 1'b0;
    end
  end

  assign feed = (pm_new[atrlp_pkg::PM_STATUS_BIT] &&
                 len_q >= LW'(atrlp_pkg::STAT_PREFIX_LEN)) ||
                (pm_new[atrlp_pkg::PM_AUDIO_BIT] &&
                 len_q >= LW'(atrlp_pkg::AUDIO_PREFIX_LEN));

  // per-byte step
  always_comb begin
    len_d     = len_q;
    eff_len_d = eff_len_q;
    pm_d      = pm_q;
    zero_d    = zero_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    status_d  = status_q;
    audio_d   = audio_q;
    halted_d  = halted_q;

    res_valid_o           = 1'b0;
    res_o.line_kind       = atrlp_pkg::KIND_OTHER;
    res_o.audio_update    = 1'b0;
    res_o.receiver_halted = 1'b0;

    if (step_i && !halted_q && rx_byte_i != atrlp_pkg::CHAR_CR) begin
      if (rx_byte_i == atrlp_pkg::CHAR_LF) begin
        // end of line
        if (len_q != '0) begin
          res_valid_o = 1'b1;
          if (pm_q[atrlp_pkg::PM_STATUS_BIT] && eff > LW'(atrlp_pkg::STAT_PREFIX_LEN)) begin
            status_d        = value;
            res_o.line_kind = atrlp_pkg::KIND_STATUS;
          end else if (pm_q[atrlp_pkg::PM_AUDIO_BIT] &&
                       eff > LW'(atrlp_pkg::AUDIO_PREFIX_LEN)) begin
            if (value != audio_q) begin
              audio_d            = value;
              res_o.audio_update = 1'b1;
            end
            res_o.line_kind = atrlp_pkg::KIND_AUDIO;
          end
          len_d     = '0;
          eff_len_d = '0;
          pm_d      = 2'b11;
          zero_d    = 1'b0;
          phase_d   = atrlp_pkg::PH_BLANKS;
          neg_d     = 1'b0;
          acc_d     = '0;
        end
      end else if (len_q >= LW'(LINE_MAX)) begin
        // overflow halts the receiver
        halted_d              = 1'b1;
        res_valid_o           = 1'b1;
        res_o.receiver_halted = 1'b1;
        len_d     = '0;
        eff_len_d = '0;
        pm_d      = 2'b11;
        zero_d    = 1'b0;
        phase_d   = atrlp_pkg::PH_BLANKS;
        neg_d     = 1'b0;
        acc_d     = '0;
      end else begin
        len_d = len_q + LW'(1);
        if (!zero_q) begin
          if (rx_byte_i == atrlp_pkg::CHAR_NUL) begin
            zero_d    = 1'b1;
            eff_len_d = len_q;
          end else begin
            pm_d = pm_new;
            // number reading after the prefix
            if (feed) begin
              case (phase_q)
                atrlp_pkg::PH_BLANKS: begin
                  if (!is_blank) begin
                    if (rx_byte_i == atrlp_pkg::CHAR_PLUS ||
                        rx_byte_i == atrlp_pkg::CHAR_MINUS) begin
                      neg_d   = (rx_byte_i == atrlp_pkg::CHAR_MINUS);
                      phase_d = atrlp_pkg::PH_DIGITS;
                    end else if (is_digit) begin
                      acc_d   = {24'd0, digit_val};
                      phase_d = atrlp_pkg::PH_DIGITS;
                    end else begin
                      phase_d = atrlp_pkg::PH_DONE;
                    end
                  end
                end
                atrlp_pkg::PH_DIGITS: begin
                  if (is_digit) begin
                    acc_d = (acc_q << 3) + (acc_q << 1) + {24'd0, digit_val};
                  end else begin
                    phase_d = atrlp_pkg::PH_DONE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
    end

    res_o.status_value = status_d;
    res_o.audio_value  = audio_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      eff_len_q <= '0;
      pm_q      <= 2'b11;
      zero_q    <= 1'b0;
      phase_q   <= atrlp_pkg::PH_BLANKS;
      neg_q     <= 1'b0;
      acc_q     <= '0;
      status_q  <= 32'(STATUS_INIT);
      audio_q   <= 32'(AUDIO_INIT);
      halted_q  <= 1'b0;
    end else begin
      len_q     <= len_d;
      eff_len_q <= eff_len_d;
      pm_q      <= pm_d;
      zero_q    <= zero_d;
      phase_q   <= phase_d;
      neg_q     <= neg_d;
      acc_q     <= acc_d;
      status_q  <= status_d;
      audio_q   <= audio_d;
      halted_q  <= halted_d;
    end
  end

endmodule

// File: hdl/at_response_line_parser.sv
// top level of the at response line parser
// input byte register, line parsing step and result register
// depends on atrlp_pkg and atrlp_line

// Takes one received byte per transaction and accepts a new byte every clock
// cycle; each byte goes through an input register, one parsing step and a
// result register, so a result enters the result register from the step on
// its line feed. Carriage returns are dropped, empty lines give no result,
// and a byte beyond LINE_MAX in one line halts reception until reset, with
// one halt result. Only back pressure on the result side slows the input.

module at_response_line_parser #(
  parameter int unsigned LINE_MAX    = 256,
  parameter int unsigned STATUS_INIT = 0,
  parameter int unsigned AUDIO_INIT  = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // status_value, audio_value, audio_update,
                                        // receiver_halted, zero fill
  output logic [1:0]  m_axis_tuser_o    // line_kind
);

  logic                    in_valid_q;
  logic [7:0]              in_byte_q;
  logic                    out_valid_q;
  atrlp_pkg::atrlp_result_t res_q;
  atrlp_pkg::atrlp_result_t res;
  logic                    res_valid;
  logic                    step;

  // step the parser when the result register can take a result
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  // input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  atrlp_line #(
    .LINE_MAX   (LINE_MAX),
    .STATUS_INIT(STATUS_INIT),
    .AUDIO_INIT (AUDIO_INIT)
  ) u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rx_byte_i  (in_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.line_kind;
  assign m_axis_tdata_o  = {6'd0, res_q.receiver_halted, res_q.audio_update,
                            res_q.audio_value, res_q.status_value};

  // a halt result carries no line kind and no audio change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.receiver_halted) |->
      (res_q.line_kind == atrlp_pkg::KIND_OTHER && !res_q.audio_update))
    else $error("halt result with line kind or audio change");

  // audio change only on audio lines
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.audio_update) |-> (res_q.line_kind == atrlp_pkg::KIND_AUDIO))
    else $error("audio change on a non-audio line");

  // nothing follows a delivered halt result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready_i && res_q.receiver_halted) |=> !out_valid_q)
    else $error("result after receiver halt");

  // a waiting input byte is kept until stepped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input byte lost before parsing");

endmodule
